>>> rtl/tekd_pkg.sv
// Shared types, key codes and byte constants for the terminal escape key decoder.
// Used by every module of the block; depends on nothing.
package tekd_pkg;

    // Key codes carried in the key field of a result.
    localparam logic [3:0] KEY_TEXT = 4'd0;
    localparam logic [3:0] KEY_RET  = 4'd1;
    localparam logic [3:0] KEY_BACK = 4'd2;
    localparam logic [3:0] KEY_TAB  = 4'd3;
    localparam logic [3:0] KEY_ESC  = 4'd4;
    localparam logic [3:0] KEY_UP   = 4'd5;
    localparam logic [3:0] KEY_DOWN = 4'd6;
    localparam logic [3:0] KEY_RGT  = 4'd7;
    localparam logic [3:0] KEY_LEFT = 4'd8;
    localparam logic [3:0] KEY_HOME = 4'd9;
    localparam logic [3:0] KEY_INS  = 4'd10;
    localparam logic [3:0] KEY_DEL  = 4'd11;
    localparam logic [3:0] KEY_END  = 4'd12;
    localparam logic [3:0] KEY_PGUP = 4'd13;
    localparam logic [3:0] KEY_PGDN = 4'd14;

    // Input item modes.
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Bytes with a meaning of their own.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CSI   = 8'h5B; // '['
    localparam logic [7:0] CH_SS3   = 8'h4F; // 'O'
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;

    // Sequence progress codes.
    localparam logic [1:0] SEQ_EMPTY = 2'd0;
    localparam logic [1:0] SEQ_DIGIT = 2'd1;
    localparam logic [1:0] SEQ_DEAD  = 2'd2;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0] key;
        logic [7:0] key_char;
        logic       alt_mod;
        logic       last;
    } t_out_item;

    // Results produced by one decoded item.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_dec_result;

    // Queue status seen by the decode stage.
    typedef struct packed {
        logic [QUEUE_AW:0] level;
        logic              room;
    } t_q_status;

    // Key class of a byte seen outside any escape.
    function automatic logic [3:0] plain_key(input logic [7:0] c);
        logic [3:0] k;
        if (c == CH_LF || c == CH_CR) begin
            k = KEY_RET;
        end else if (c == CH_DEL || c == CH_BS) begin
            k = KEY_BACK;
        end else if (c == CH_TAB) begin
            k = KEY_TAB;
        end else begin
            k = KEY_TEXT;
        end
        return k;
    endfunction

    // Navigation key for "<digit>~"; digit is '1'..'6'.
    function automatic logic [3:0] digit_key(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            8'h31:   k = KEY_HOME;
            8'h32:   k = KEY_INS;
            8'h33:   k = KEY_DEL;
            8'h34:   k = KEY_END;
            8'h35:   k = KEY_PGUP;
            8'h36:   k = KEY_PGDN;
            default: k = KEY_TEXT;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/terminal_escape_key_decoder_core.sv
// Top level of the terminal escape key decoder: input register, decode stage, result queue.
// Depends on tekd_pkg, tekd_decode and tekd_out_queue.

// The block takes one transaction per clock while o_ready is high: a received
// byte or an end-of-batch marker, and returns zero, one or two key events for it,
// the final one flagged by last. An item is held in the input register, is decoded
// there against the escape state and its results are written into a four-entry
// result queue, from which the first event is offered. One item is decoded per
// cycle as long as the queue has room for two more results; the output side moves
// one event per cycle while i_ready is high, so a stream of items that each give
// two events is held back to the rate at which the queue drains.
module terminal_escape_key_decoder_core
    import tekd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic        r_vld;
    t_in_item    r_item;
    logic        fire;
    t_dec_result dec;
    t_q_status   q_status;

    assign fire    = r_vld && q_status.room;
    assign o_ready = !r_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    tekd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .o_dec   (dec)
    );

    tekd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_dec    (dec),
        .o_status (q_status),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_item)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("result queue level beyond its depth");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !fire |=> r_vld && $stable(r_item))
        else $error("stalled item left the input register");

    a_pair_is_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && dec.cnt == 2'd2 |-> dec.res0.key == KEY_ESC && !dec.res0.last)
        else $error("two results without a leading escape event");

    a_valid_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("offered result dropped without a transaction");

endmodule

>>> rtl/tekd_decode.sv
// Escape decode stage: holds the escape state and turns one item into up to two results.
// Depends on tekd_pkg.
module tekd_decode
    import tekd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_item    i_item,
    output t_dec_result o_dec
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ESC  = 2'd1,
        ST_SEQ  = 2'd2
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_pend, n_pend;
    logic [1:0] r_len, n_len;

    logic [7:0] c;
    logic       hit;
    logic [3:0] hit_key;

    assign c = i_item.rx_byte;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_len       = r_len;
        o_dec       = '0;
        hit         = 1'b0;
        hit_key     = KEY_TEXT;
        if (i_item.mode == MODE_FLUSH) begin
            if (r_state == ST_ESC) begin
                o_dec.cnt  = 2'd1;
                o_dec.res0 = '{key: KEY_ESC, key_char: CH_ESC, alt_mod: 1'b0, last: 1'b0};
            end
            n_state = ST_IDLE;
            n_pend  = '0;
            n_len   = SEQ_EMPTY;
        end else begin
            unique case (r_state)
                ST_ESC: begin
                    if (c == CH_CSI || c == CH_SS3) begin
                        n_state = ST_SEQ;
                        n_pend  = '0;
                        n_len   = SEQ_EMPTY;
                    end else if (c == CH_TAB) begin
                        o_dec.cnt  = 2'd1;
                        o_dec.res0 = '{key: KEY_TAB, key_char: CH_TAB, alt_mod: 1'b1,
                                       last: 1'b0};
                        n_state    = ST_IDLE;
                        n_pend     = '0;
                        n_len      = SEQ_EMPTY;
                    end else begin
                        o_dec.res0 = '{key: KEY_ESC, key_char: c, alt_mod: 1'b0, last: 1'b0};
                        n_pend     = '0;
                        n_len      = SEQ_EMPTY;
                        // A second ESC gives an escape event and re-arms the escape;
                        // anything else is also decoded as a plain byte.
                        if (c == CH_ESC) begin
                            o_dec.cnt = 2'd1;
                            n_state   = ST_ESC;
                        end else begin
                            o_dec.cnt  = 2'd2;
                            o_dec.res1 = '{key: plain_key(c), key_char: c, alt_mod: 1'b0,
                                           last: 1'b0};
                            n_state    = ST_IDLE;
                        end
                    end
                end
                ST_SEQ: begin
                    if (r_len == SEQ_EMPTY) begin
                        priority if (c == CH_A) begin
                            hit = 1'b1; hit_key = KEY_UP;
                        end else if (c == CH_B) begin
                            hit = 1'b1; hit_key = KEY_DOWN;
                        end else if (c == CH_C) begin
                            hit = 1'b1; hit_key = KEY_RGT;
                        end else if (c == CH_D) begin
                            hit = 1'b1; hit_key = KEY_LEFT;
                        end else if (c == CH_H) begin
                            hit = 1'b1; hit_key = KEY_HOME;
                        end else if (c == CH_F) begin
                            hit = 1'b1; hit_key = KEY_END;
                        end else if (c >= CH_ONE && c <= CH_SIX) begin
                            n_pend = c;
                            n_len  = SEQ_DIGIT;
                        end else begin
                            n_len = SEQ_DEAD;
                        end
                    end else if (r_len == SEQ_DIGIT) begin
                        if (c == CH_TILDE && r_pend >= CH_ONE && r_pend <= CH_SIX) begin
                            hit     = 1'b1;
                            hit_key = digit_key(r_pend);
                        end else begin
                            n_len = SEQ_DEAD;
                        end
                    end
                    if (hit) begin
                        o_dec.cnt  = 2'd1;
                        o_dec.res0 = '{key: hit_key, key_char: 8'h00, alt_mod: 1'b0,
                                       last: 1'b0};
                        n_state    = ST_IDLE;
                        n_pend     = '0;
                        n_len      = SEQ_EMPTY;
                    end
                end
                default: begin
                    if (c == CH_ESC) begin
                        n_state = ST_ESC;
                        n_pend  = '0;
                        n_len   = SEQ_EMPTY;
                    end else begin
                        o_dec.cnt  = 2'd1;
                        o_dec.res0 = '{key: plain_key(c), key_char: c, alt_mod: 1'b0,
                                       last: 1'b0};
                        n_state    = ST_IDLE;
                    end
                end
            endcase
        end
        o_dec.res0.last = (o_dec.cnt == 2'd1);
        o_dec.res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_len   <= SEQ_EMPTY;
        end else if (i_fire) begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_len   <= n_len;
        end
    end

endmodule

>>> rtl/tekd_out_queue.sv
// Result queue: takes zero, one or two results per cycle and hands out one per transaction.
// Depends on tekd_pkg.
module tekd_out_queue
    import tekd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_dec_result i_dec,
    output t_q_status   o_status,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    t_out_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, r_rptr;
    logic [QUEUE_AW:0]     r_level;
    logic [1:0]            push_cnt;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wptr_1;

    assign push_cnt = i_push ? i_dec.cnt : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wptr_1   = r_wptr + QUEUE_AW'(1);

    assign o_valid         = (r_level != '0);
    assign o_item          = r_mem[r_rptr];
    // Room for the largest burst one item can cause.
    assign o_status.level  = r_level;
    assign o_status.room   = (r_level <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_dec.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wptr_1] <= i_dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + QUEUE_AW'(push_cnt);
            r_rptr  <= r_rptr + QUEUE_AW'(pop);
            r_level <= r_level + (QUEUE_AW + 1)'(push_cnt) - (QUEUE_AW + 1)'(pop);
        end
    end

endmodule

>>> tb/sv/tb_terminal_escape_key_decoder_core.sv
// Self-checking testbench for terminal_escape_key_decoder_core: drives byte and end-of-batch
// transactions and checks every key event against an in-bench decoder model.
// Depends on tekd_pkg and the RTL of terminal_escape_key_decoder_core.
`timescale 1ns / 100ps

module tb_terminal_escape_key_decoder_core;
    import tekd_pkg::*;

    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_ESC,
        PHASE_SEQ
    } t_esc_phase;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    // Decoder model state.
    t_esc_phase esc_phase    = PHASE_IDLE;
    logic [7:0] held_digit   = 8'h00;
    logic [1:0] seq_progress = SEQ_EMPTY;

    t_out_item key_events[$];
    int        error_count = 0;
    int        sent_items  = 0;
    bit        quiet       = 1'b0;
    int        stall_left  = 0;

    terminal_escape_key_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item make_event(input logic [3:0] k, input logic [7:0] c,
                                             input logic alt);
        t_out_item e;
        e.key      = k;
        e.key_char = c;
        e.alt_mod  = alt;
        e.last     = 1'b0;
        return e;
    endfunction

    function automatic logic [3:0] byte_class(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LF, CH_CR:  k = KEY_RET;
            CH_DEL, CH_BS: k = KEY_BACK;
            CH_TAB:        k = KEY_TAB;
            default:       k = KEY_TEXT;
        endcase
        return k;
    endfunction

    task automatic enter_idle();
        esc_phase    = PHASE_IDLE;
        held_digit   = 8'h00;
        seq_progress = SEQ_EMPTY;
    endtask

    // Works out the key events of one accepted transaction and queues them.
    task automatic predict_key_events(input t_in_item it);
        t_out_item  ev[$];
        logic       plain;
        logic [7:0] c;
        logic [7:0] idx;
        logic [3:0] nav;
        c     = it.rx_byte;
        plain = 1'b0;
        if (it.mode == MODE_FLUSH) begin
            if (esc_phase == PHASE_ESC) begin
                ev = {ev, make_event(KEY_ESC, CH_ESC, 1'b0)};
            end
            enter_idle();
        end else begin
            case (esc_phase)
                PHASE_ESC: begin
                    if (c == CH_CSI || c == CH_SS3) begin
                        esc_phase    = PHASE_SEQ;
                        held_digit   = 8'h00;
                        seq_progress = SEQ_EMPTY;
                    end else if (c == CH_TAB) begin
                        ev = {ev, make_event(KEY_TAB, CH_TAB, 1'b1)};
                        enter_idle();
                    end else begin
                        ev = {ev, make_event(KEY_ESC, c, 1'b0)};
                        enter_idle();
                        plain = 1'b1;
                    end
                end
                PHASE_SEQ: begin
                    if (seq_progress == SEQ_EMPTY) begin
                        nav = KEY_TEXT;
                        case (c)
                            CH_A: nav = KEY_UP;
                            CH_B: nav = KEY_DOWN;
                            CH_C: nav = KEY_RGT;
                            CH_D: nav = KEY_LEFT;
                            CH_H: nav = KEY_HOME;
                            CH_F: nav = KEY_END;
                            default: begin
                                if (c >= CH_ONE && c <= CH_SIX) begin
                                    held_digit   = c;
                                    seq_progress = SEQ_DIGIT;
                                end else begin
                                    seq_progress = SEQ_DEAD;
                                end
                            end
                        endcase
                        if (nav != KEY_TEXT) begin
                            ev = {ev, make_event(nav, 8'h00, 1'b0)};
                            enter_idle();
                        end
                    end else if (seq_progress == SEQ_DIGIT) begin
                        if (c == CH_TILDE) begin
                            idx = held_digit - CH_ONE;
                            case (idx)
                                8'd0:    nav = KEY_HOME;
                                8'd1:    nav = KEY_INS;
                                8'd2:    nav = KEY_DEL;
                                8'd3:    nav = KEY_END;
                                8'd4:    nav = KEY_PGUP;
                                default: nav = KEY_PGDN;
                            endcase
                            ev = {ev, make_event(nav, 8'h00, 1'b0)};
                            enter_idle();
                        end else begin
                            seq_progress = SEQ_DEAD;
                        end
                    end
                    // A dead sequence swallows everything until end of batch.
                end
                default: plain = 1'b1;
            endcase
        end

        // The byte after a lone ESC is decoded again as an ordinary byte.
        if (plain) begin
            if (c == CH_ESC) begin
                esc_phase    = PHASE_ESC;
                held_digit   = 8'h00;
                seq_progress = SEQ_EMPTY;
            end else begin
                ev = {ev, make_event(byte_class(c), c, 1'b0)};
            end
        end

        if (ev.size() > 0) begin
            ev[ev.size() - 1].last = 1'b1;
        end
        key_events = {key_events, ev};
    endtask

    task automatic send_item(input logic m, input logic [7:0] b);
        t_in_item it;
        it.mode    = m;
        it.rx_byte = b;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_key_events(it);
        sent_items++;
    endtask

    // Called right after an accepted transaction; drops valid and lets the queue empty.
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (key_events.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_key_event
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (key_events.size() == 0) begin
                $error("unexpected key event: key %0d char 0x%02h alt %0d last %0d",
                       o_item.key, o_item.key_char, o_item.alt_mod, o_item.last);
                error_count++;
            end else begin
                want = key_events.pop_front();
                check_field("key", want.key, o_item.key);
                check_field("key_char", want.key_char, o_item.key_char);
                check_field("alt_mod", want.alt_mod, o_item.alt_mod);
                check_field("last", want.last, o_item.last);
            end
        end
    end

    task automatic test_plain_keys();
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, CH_LF);
        send_item(MODE_BYTE, CH_CR);
        send_item(MODE_BYTE, CH_DEL);
        send_item(MODE_BYTE, CH_BS);
        send_item(MODE_BYTE, CH_TAB);
        wait_for_idle();
    endtask

    task automatic test_navigation_keys();
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_CSI);
        send_item(MODE_BYTE, CH_A);
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_SS3);
        send_item(MODE_BYTE, CH_H);
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_CSI);
        send_item(MODE_BYTE, CH_SIX);
        send_item(MODE_BYTE, CH_TILDE);
        wait_for_idle();
    endtask

    task automatic test_escape_corner_cases();
        // Alt+Tab, then ESC ESC and a letter after the second ESC.
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_TAB);
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, 8'h71);
        // A lone ESC is flushed by the end of the batch.
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_FLUSH, 8'hFF);
        // An unknown sequence swallows bytes, ESC included.
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_CSI);
        send_item(MODE_BYTE, 8'h5A);
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_FLUSH, 8'h00);
        // An unfinished sequence is dropped, and a flush while idle does nothing.
        send_item(MODE_BYTE, CH_ESC);
        send_item(MODE_BYTE, CH_SS3);
        send_item(MODE_BYTE, CH_ONE);
        send_item(MODE_FLUSH, 8'h00);
        send_item(MODE_FLUSH, 8'h1B);
        wait_for_idle();
    endtask

    // Well-formed escape sequences, mixed with text, broken sequences and flushes.
    task automatic send_random_phrase();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            send_item(MODE_BYTE, CH_ESC);
            send_item(MODE_BYTE, $urandom_range(0, 1) ? CH_CSI : CH_SS3);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       b = CH_A;
                    1:       b = CH_B;
                    2:       b = CH_C;
                    3:       b = CH_D;
                    4:       b = CH_H;
                    default: b = CH_F;
                endcase
                send_item(MODE_BYTE, b);
            end else begin
                b = 8'($urandom_range(0, 5));
                send_item(MODE_BYTE, b + CH_ONE);
                send_item(MODE_BYTE, CH_TILDE);
            end
        end else if (kind < 55) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       b = CH_LF;
                    1:       b = CH_CR;
                    2:       b = CH_DEL;
                    3:       b = CH_BS;
                    default: b = CH_TAB;
                endcase
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_item(MODE_BYTE, b);
        end else if (kind < 65) begin
            send_item(MODE_BYTE, CH_ESC);
            b = 8'($urandom_range(0, 255));
            send_item(MODE_BYTE, b);
        end else if (kind < 73) begin
            send_item(MODE_BYTE, CH_ESC);
            send_item(MODE_BYTE, $urandom_range(0, 1) ? CH_TAB : CH_ESC);
        end else if (kind < 88) begin
            send_item(MODE_BYTE, CH_ESC);
            send_item(MODE_BYTE, $urandom_range(0, 1) ? CH_CSI : CH_SS3);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: begin
                        b = 8'($urandom_range(0, 8));
                        b = b + CH_ONE;
                    end
                    1:       b = CH_TILDE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_item(MODE_BYTE, b);
            end
            if ($urandom_range(0, 1)) begin
                send_item(MODE_FLUSH, 8'h00);
            end
        end else begin
            b = 8'($urandom_range(0, 255));
            send_item(MODE_FLUSH, b);
        end
    endtask

    task automatic test_random_streams(input int count);
        int stop_at;
        stop_at = sent_items + count;
        while (sent_items < stop_at) send_random_phrase();
        wait_for_idle();
    endtask

    task automatic test_back_to_back(input int count);
        int stop_at;
        quiet   = 1'b1;
        stop_at = sent_items + count;
        while (sent_items < stop_at) send_random_phrase();
        wait_for_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_keys();
        test_navigation_keys();
        test_escape_corner_cases();
        test_random_streams(1350);
        test_back_to_back(300);
        if (error_count == 0) begin
            $display("terminal_escape_key_decoder_core test passed");
        end else begin
            $display("terminal_escape_key_decoder_core test failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("terminal_escape_key_decoder_core test failed");
        $finish;
    end

endmodule
